// ----- rtl/fhs_pkg.sv -----
// fhs_pkg: shared constants, types and the heat palette for the fire heat spread block
// no dependencies; every rtl file uses it through scoped names

package fhs_pkg;

    // grid storage
    localparam int MAX_CELLS = 8192;
    localparam int CELL_AW   = $clog2(MAX_CELLS);

    // field widths
    localparam int WIDTH_W  = 8;
    localparam int HEIGHT_W = 7;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 7;
    localparam int HEAT_W   = 6;
    localparam int PIX_W    = 13;
    localparam int DRIFT_W  = 2;
    localparam int DECAY_W  = 3;
    localparam int RGB_W    = 8;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 8;

    // grid index arithmetic: width * height reaches 8192, plus room for storage compares
    localparam int IDX_W = 14;
    localparam int CMP_W = ((CELL_AW + 1 > IDX_W) ? CELL_AW + 1 : IDX_W) + 1;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_GRID_HEIGHT = 2'd1;

    // register reset values and clamp limits
    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 8'd80;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 7'd24;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = 8'd1;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = 8'd128;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 7'd2;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 7'd64;
    localparam logic [CMP_W-1:0]    RST_BASE   =
        CMP_W'((int'(RST_HEIGHT) - 1) * int'(RST_WIDTH));
    localparam logic [ROW_W-1:0]    RST_ROW    = ROW_W'(int'(RST_HEIGHT) - 1);

    // hottest cell value
    localparam logic [HEAT_W-1:0] HEAT_MAX = 6'd35;

    // request kinds
    typedef enum logic [1:0] {
        REQ_INIT   = 2'd0,
        REQ_SPREAD = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    // effective grid geometry
    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [CMP_W-1:0]    cells;
        logic [CMP_W-1:0]    base;
    } t_cfg;

    // scan position decode for the current spread step
    typedef struct packed {
        logic [CMP_W-1:0] src;
        logic             src_in;
        logic [CMP_W-1:0] dst;
        logic             dst_in;
        logic             pass_end;
    } t_scan;

    // heat to rgb, black above the hottest value
    function automatic logic [3*RGB_W-1:0] palette_rgb(input logic [HEAT_W-1:0] h);
        logic [3*RGB_W-1:0] rgb;
        unique case (h)
            6'd0:    rgb = 24'h070707;
            6'd1:    rgb = 24'h1f0707;
            6'd2:    rgb = 24'h2f0f07;
            6'd3:    rgb = 24'h470f07;
            6'd4:    rgb = 24'h571707;
            6'd5:    rgb = 24'h671f07;
            6'd6:    rgb = 24'h771f07;
            6'd7:    rgb = 24'h8f2707;
            6'd8:    rgb = 24'h9f2f07;
            6'd9:    rgb = 24'haf3f07;
            6'd10:   rgb = 24'hbf4707;
            6'd11:   rgb = 24'hc74707;
            6'd12:   rgb = 24'hdf4f07;
            6'd13:   rgb = 24'hdf5707;
            6'd14:   rgb = 24'hdf5707;
            6'd15:   rgb = 24'hd75f07;
            6'd16:   rgb = 24'hd7670f;
            6'd17:   rgb = 24'hcf6f0f;
            6'd18:   rgb = 24'hcf770f;
            6'd19:   rgb = 24'hcf7f0f;
            6'd20:   rgb = 24'hcf8717;
            6'd21:   rgb = 24'hc78717;
            6'd22:   rgb = 24'hc78f17;
            6'd23:   rgb = 24'hc7971f;
            6'd24:   rgb = 24'hbf9f1f;
            6'd25:   rgb = 24'hbf9f1f;
            6'd26:   rgb = 24'hbfa727;
            6'd27:   rgb = 24'hbfa727;
            6'd28:   rgb = 24'hbfaf2f;
            6'd29:   rgb = 24'hb7af2f;
            6'd30:   rgb = 24'hb7b72f;
            6'd31:   rgb = 24'hb7b737;
            6'd32:   rgb = 24'hcfcf6f;
            6'd33:   rgb = 24'hdfdf9f;
            6'd34:   rgb = 24'hefefc7;
            6'd35:   rgb = 24'hffffff;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

// ----- rtl/fhs_cfg.sv -----
// fhs_cfg: grid width and height registers with clamping and derived geometry
// depends on fhs_pkg

module fhs_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [fhs_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [fhs_pkg::CFG_DW-1:0] i_cfg_data,
    output fhs_pkg::t_cfg              o_cfg,
    output logic                       o_restart,
    output logic [fhs_pkg::ROW_W-1:0]  o_restart_row
);

    logic [fhs_pkg::WIDTH_W-1:0]  r_grid_width;
    logic [fhs_pkg::HEIGHT_W-1:0] r_grid_height;
    logic [fhs_pkg::WIDTH_W-1:0]  eff_w;
    logic [fhs_pkg::HEIGHT_W-1:0] eff_h;
    logic [fhs_pkg::HEIGHT_W-1:0] new_h;
    logic [fhs_pkg::HEIGHT_W-1:0] new_hm1;
    logic [fhs_pkg::HEIGHT_W-1:0] eff_hm1;
    logic [fhs_pkg::CMP_W-1:0]    prod;
    logic                         wr_w;
    logic                         wr_h;

    function automatic logic [fhs_pkg::WIDTH_W-1:0] clamp_w(
        input logic [fhs_pkg::WIDTH_W-1:0] w
    );
        logic [fhs_pkg::WIDTH_W-1:0] r;
        r = w;
        if (w < fhs_pkg::WIDTH_MIN) r = fhs_pkg::WIDTH_MIN;
        if (w > fhs_pkg::WIDTH_MAX) r = fhs_pkg::WIDTH_MAX;
        return r;
    endfunction

    function automatic logic [fhs_pkg::HEIGHT_W-1:0] clamp_h(
        input logic [fhs_pkg::HEIGHT_W-1:0] h
    );
        logic [fhs_pkg::HEIGHT_W-1:0] r;
        r = h;
        if (h < fhs_pkg::HEIGHT_MIN) r = fhs_pkg::HEIGHT_MIN;
        if (h > fhs_pkg::HEIGHT_MAX) r = fhs_pkg::HEIGHT_MAX;
        return r;
    endfunction

    assign wr_w = i_cfg_valid && (i_cfg_index == fhs_pkg::REG_GRID_WIDTH);
    assign wr_h = i_cfg_valid && (i_cfg_index == fhs_pkg::REG_GRID_HEIGHT);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= fhs_pkg::RST_WIDTH;
            r_grid_height <= fhs_pkg::RST_HEIGHT;
        end else begin
            if (wr_w) r_grid_width <= i_cfg_data;
            if (wr_h) r_grid_height <= i_cfg_data[fhs_pkg::HEIGHT_W-1:0];
        end
    end

    // effective geometry
    always_comb begin
        eff_w   = clamp_w(r_grid_width);
        eff_h   = clamp_h(r_grid_height);
        eff_hm1 = eff_h - 7'd1;
        prod    = fhs_pkg::CMP_W'(eff_w) * fhs_pkg::CMP_W'(eff_h);
        o_cfg.width  = eff_w;
        o_cfg.height = eff_h;
        o_cfg.cells  = (prod < fhs_pkg::CMP_W'(fhs_pkg::MAX_CELLS))
                     ? prod : fhs_pkg::CMP_W'(fhs_pkg::MAX_CELLS);
        o_cfg.base   = fhs_pkg::CMP_W'(eff_hm1) * fhs_pkg::CMP_W'(eff_w);
    end

    // scan restart row follows the height being written
    always_comb begin
        new_h         = wr_h ? clamp_h(i_cfg_data[fhs_pkg::HEIGHT_W-1:0]) : eff_h;
        new_hm1       = new_h - 7'd1;
        o_restart     = wr_w || wr_h;
        o_restart_row = new_hm1[fhs_pkg::ROW_W-1:0];
    end

endmodule

// ----- rtl/fhs_scan.sv -----
// fhs_scan: spread scan position and source/destination cell decode
// depends on fhs_pkg

module fhs_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fhs_pkg::t_cfg               i_cfg,
    input  logic                        i_restart,
    input  logic [fhs_pkg::ROW_W-1:0]   i_restart_row,
    input  logic                        i_init,
    input  logic                        i_step,
    input  logic [fhs_pkg::DRIFT_W-1:0] i_drift,
    output fhs_pkg::t_scan              o_scan
);

    logic [fhs_pkg::ROW_W-1:0]    r_scan_row;
    logic [fhs_pkg::COL_W-1:0]    r_scan_col;
    logic [fhs_pkg::ROW_W-1:0]    n_scan_row;
    logic [fhs_pkg::COL_W-1:0]    n_scan_col;
    logic [fhs_pkg::COL_W:0]      col_inc;
    logic                         row_end;
    logic [fhs_pkg::HEIGHT_W-1:0] hm1;
    logic [fhs_pkg::ROW_W-1:0]    top_row;
    logic [fhs_pkg::CMP_W-1:0]    src;
    logic [fhs_pkg::CMP_W-1:0]    src_drift;
    logic [fhs_pkg::CMP_W-1:0]    w_plus1;
    logic [fhs_pkg::CMP_W-1:0]    dst;

    // cell decode: one row up, shifted by drift minus one, floored at zero
    always_comb begin
        src = fhs_pkg::CMP_W'(r_scan_row) * fhs_pkg::CMP_W'(i_cfg.width)
            + fhs_pkg::CMP_W'(r_scan_col);
        src_drift = src + fhs_pkg::CMP_W'(i_drift);
        w_plus1   = fhs_pkg::CMP_W'(i_cfg.width) + fhs_pkg::CMP_W'(1);
        dst       = (src_drift < w_plus1) ? '0 : src_drift - w_plus1;
        col_inc   = {1'b0, r_scan_col} + 8'd1;
        row_end   = (col_inc >= i_cfg.width);
        o_scan.src      = src;
        o_scan.src_in   = (src < fhs_pkg::CMP_W'(fhs_pkg::MAX_CELLS));
        o_scan.dst      = dst;
        o_scan.dst_in   = (dst < i_cfg.cells);
        o_scan.pass_end = row_end && (r_scan_row <= 6'd1);
    end

    // next scan position
    always_comb begin
        hm1        = i_cfg.height - 7'd1;
        top_row    = hm1[fhs_pkg::ROW_W-1:0];
        n_scan_row = r_scan_row;
        n_scan_col = r_scan_col;
        if (i_restart) begin
            n_scan_row = i_restart_row;
            n_scan_col = '0;
        end else if (i_init) begin
            n_scan_row = top_row;
            n_scan_col = '0;
        end else if (i_step) begin
            if (row_end) begin
                n_scan_col = '0;
                n_scan_row = o_scan.pass_end ? top_row : r_scan_row - 6'd1;
            end else begin
                n_scan_col = col_inc[fhs_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row <= fhs_pkg::RST_ROW;
            r_scan_col <= '0;
        end else begin
            r_scan_row <= n_scan_row;
            r_scan_col <= n_scan_col;
        end
    end

endmodule

// ----- rtl/fhs_grid.sv -----
// fhs_grid: heat grid memory with registered read, write forwarding and the clearing sweep
// depends on fhs_pkg

module fhs_grid (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_sweep_start,
    input  logic [fhs_pkg::CMP_W-1:0]   i_sweep_base,
    input  logic [fhs_pkg::WIDTH_W-1:0] i_sweep_width,
    output logic                        o_busy,
    input  logic                        i_re,
    input  logic [fhs_pkg::CELL_AW-1:0] i_raddr,
    output logic [fhs_pkg::HEAT_W-1:0]  o_rdata,
    input  logic                        i_we,
    input  logic [fhs_pkg::CELL_AW-1:0] i_waddr,
    input  logic [fhs_pkg::HEAT_W-1:0]  i_wdata
);

    logic [fhs_pkg::HEAT_W-1:0]  r_mem [fhs_pkg::MAX_CELLS];
    logic [fhs_pkg::HEAT_W-1:0]  r_rd_data;
    logic [fhs_pkg::CELL_AW-1:0] r_rd_addr;
    logic                        r_fwd_valid;
    logic [fhs_pkg::CELL_AW-1:0] r_fwd_addr;
    logic [fhs_pkg::HEAT_W-1:0]  r_fwd_data;
    logic                        r_sweep;
    logic [fhs_pkg::CELL_AW-1:0] r_cnt;
    logic [fhs_pkg::CMP_W-1:0]   r_clr_base;
    logic [fhs_pkg::WIDTH_W-1:0] r_clr_width;
    logic [fhs_pkg::CMP_W-1:0]   cnt_ext;
    logic                        cnt_bottom;
    logic                        mem_we;
    logic [fhs_pkg::CELL_AW-1:0] mem_waddr;
    logic [fhs_pkg::HEAT_W-1:0]  mem_wdata;

    // sweep writes zero, or full heat along the bottom row
    always_comb begin
        cnt_ext    = fhs_pkg::CMP_W'(r_cnt);
        cnt_bottom = (cnt_ext >= r_clr_base)
                  && (cnt_ext < r_clr_base + fhs_pkg::CMP_W'(r_clr_width));
        mem_we     = r_sweep || i_we;
        mem_waddr  = r_sweep ? r_cnt : i_waddr;
        mem_wdata  = r_sweep ? (cnt_bottom ? fhs_pkg::HEAT_MAX : '0) : i_wdata;
    end

    // sweep control, runs after reset and on every init
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= 1'b1;
            r_cnt       <= '0;
            r_clr_base  <= fhs_pkg::RST_BASE;
            r_clr_width <= fhs_pkg::RST_WIDTH;
        end else if (i_sweep_start) begin
            r_sweep     <= 1'b1;
            r_cnt       <= '0;
            r_clr_base  <= i_sweep_base;
            r_clr_width <= i_sweep_width;
        end else if (r_sweep) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == fhs_pkg::CELL_AW'(fhs_pkg::MAX_CELLS - 1)) r_sweep <= 1'b0;
        end
    end

    // memory array, read-first
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
            r_rd_addr <= i_raddr;
        end
    end

    // last write, for a read issued at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (r_sweep) begin
            r_fwd_valid <= 1'b0;
        end else if (i_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_fwd_addr <= i_waddr;
            r_fwd_data <= i_wdata;
        end
    end

    assign o_rdata = (r_fwd_valid && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_data;
    assign o_busy  = r_sweep;

endmodule

// ----- rtl/fire_heat_spread.sv -----
// fire_heat_spread: top level, request decode, read-modify-write stage and output word register
// depends on fhs_pkg, fhs_cfg, fhs_scan, fhs_grid
// pipeline: two register stages, stage one and then the output word register
// throughput: one word per cycle through the grid memory port barring output stalls and sweeps
// init: its result word takes the same path; input then stalls while the clearing sweep
// rewrites every cell (MAX_CELLS) through the single memory write port
// reset: synchronous, active low; the same sweep runs before the first word is taken,
// configuration writes are taken at any time

module fire_heat_spread (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input words
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [fhs_pkg::PIX_W-1:0]   i_pixel_index,
    input  logic [fhs_pkg::DRIFT_W-1:0] i_drift,
    input  logic [fhs_pkg::DECAY_W-1:0] i_decay,
    // result words
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [fhs_pkg::PIX_W-1:0]   o_cell_index,
    output logic [fhs_pkg::HEAT_W-1:0]  o_heat,
    output logic [fhs_pkg::RGB_W-1:0]   o_red,
    output logic [fhs_pkg::RGB_W-1:0]   o_green,
    output logic [fhs_pkg::RGB_W-1:0]   o_blue,
    output logic                        o_pass_end,
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fhs_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [fhs_pkg::CFG_DW-1:0]  i_cfg_data
);

    fhs_pkg::t_cfg               cfg;
    fhs_pkg::t_scan              scan;
    fhs_pkg::t_req               req;
    logic                        restart;
    logic [fhs_pkg::ROW_W-1:0]   restart_row;
    logic                        sweep_busy;
    logic                        accept;
    logic                        s1_adv;
    logic                        s1_free;
    logic [fhs_pkg::CMP_W-1:0]   pix_ext;
    logic                        pix_in;
    logic                        rd_en;
    logic [fhs_pkg::CELL_AW-1:0] rd_addr;
    logic [fhs_pkg::HEAT_W-1:0]  rd_data;
    logic                        s1_we;
    logic [fhs_pkg::HEAT_W-1:0]  h;
    logic [fhs_pkg::HEAT_W-1:0]  drop;
    logic [fhs_pkg::HEAT_W-1:0]  nh;
    logic [3*fhs_pkg::RGB_W-1:0] rgb;

    // stage one registers
    logic                        r_s1_valid;
    fhs_pkg::t_req               r_s1_req;
    logic                        r_s1_use;
    logic                        r_s1_wr;
    logic [fhs_pkg::CELL_AW-1:0] r_s1_waddr;
    logic [fhs_pkg::PIX_W-1:0]   r_s1_idx;
    logic [fhs_pkg::DECAY_W-1:0] r_s1_decay;
    logic                        r_s1_pass;

    // output word register
    logic                        r_out_valid;
    logic [fhs_pkg::PIX_W-1:0]   r_out_idx;
    logic [fhs_pkg::HEAT_W-1:0]  r_out_heat;
    logic [3*fhs_pkg::RGB_W-1:0] r_out_rgb;
    logic                        r_out_pass;

    fhs_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg         (cfg),
        .o_restart     (restart),
        .o_restart_row (restart_row)
    );

    fhs_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_restart     (restart),
        .i_restart_row (restart_row),
        .i_init        (accept && (req == fhs_pkg::REQ_INIT)),
        .i_step        (accept && (req == fhs_pkg::REQ_SPREAD)),
        .i_drift       (i_drift),
        .o_scan        (scan)
    );

    fhs_grid u_grid (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sweep_start (accept && (req == fhs_pkg::REQ_INIT)),
        .i_sweep_base  (cfg.base),
        .i_sweep_width (cfg.width),
        .o_busy        (sweep_busy),
        .i_re          (rd_en),
        .i_raddr       (rd_addr),
        .o_rdata       (rd_data),
        .i_we          (s1_we),
        .i_waddr       (r_s1_waddr),
        .i_wdata       (nh)
    );

    // handshake
    assign o_cfg_ready = 1'b1;
    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_free     = !r_s1_valid || s1_adv;
    assign o_in_stall  = sweep_busy || !s1_free;
    assign accept      = i_in_valid && !o_in_stall;

    // request decode and memory read issue
    always_comb begin
        req     = fhs_pkg::t_req'(i_req_type);
        pix_ext = fhs_pkg::CMP_W'(i_pixel_index);
        pix_in  = (pix_ext < cfg.cells);
        rd_en   = accept && (((req == fhs_pkg::REQ_SPREAD) && scan.src_in)
                         || ((req == fhs_pkg::REQ_READ) && pix_in));
        rd_addr = (req == fhs_pkg::REQ_READ) ? pix_ext[fhs_pkg::CELL_AW-1:0]
                                             : scan.src[fhs_pkg::CELL_AW-1:0];
    end

    // stage one capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req   <= req;
            r_s1_use   <= rd_en;
            r_s1_wr    <= (req == fhs_pkg::REQ_SPREAD) && scan.dst_in;
            r_s1_waddr <= scan.dst[fhs_pkg::CELL_AW-1:0];
            r_s1_decay <= i_decay;
            r_s1_pass  <= (req == fhs_pkg::REQ_SPREAD) && scan.pass_end;
            case (req)
                fhs_pkg::REQ_SPREAD: r_s1_idx <= scan.dst[fhs_pkg::PIX_W-1:0];
                fhs_pkg::REQ_READ:   r_s1_idx <= i_pixel_index;
                default:             r_s1_idx <= '0;
            endcase
        end
    end

    // heat update and palette lookup
    always_comb begin
        h     = r_s1_use ? rd_data : '0;
        drop  = fhs_pkg::HEAT_W'(r_s1_decay) + 6'd2;
        nh    = (h > drop) ? h - drop : '0;
        rgb   = fhs_pkg::palette_rgb(h);
        s1_we = s1_adv && (r_s1_req == fhs_pkg::REQ_SPREAD) && r_s1_wr;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_idx  <= r_s1_idx;
            r_out_pass <= r_s1_pass;
            case (r_s1_req)
                fhs_pkg::REQ_SPREAD: begin
                    r_out_heat <= nh;
                    r_out_rgb  <= '0;
                end
                fhs_pkg::REQ_READ: begin
                    r_out_heat <= h;
                    r_out_rgb  <= r_s1_use ? rgb : '0;
                end
                default: begin
                    r_out_heat <= '0;
                    r_out_rgb  <= '0;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_index = r_out_idx;
    assign o_heat       = r_out_heat;
    assign o_red        = r_out_rgb[3*fhs_pkg::RGB_W-1:2*fhs_pkg::RGB_W];
    assign o_green      = r_out_rgb[2*fhs_pkg::RGB_W-1:fhs_pkg::RGB_W];
    assign o_blue       = r_out_rgb[fhs_pkg::RGB_W-1:0];
    assign o_pass_end   = r_out_pass;

    // the sweep owns the write port alone
    a_sweep_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep_busy |-> !s1_we)
        else $error("spread write during clearing sweep");

    // only the init word that started a sweep can sit in stage one meanwhile
    a_sweep_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sweep_busy && r_s1_valid) |-> (r_s1_req == fhs_pkg::REQ_INIT))
        else $error("word other than init in flight during sweep");

    // stored and reported heat never exceeds the hottest value
    a_heat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_heat <= fhs_pkg::HEAT_MAX))
        else $error("result heat out of range");

    // pass end only follows a spread word through stage one
    a_pass_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_pass) |-> (r_s1_req == fhs_pkg::REQ_SPREAD))
        else $error("pass end on a non-spread word");

endmodule

// ----- verif/fire_heat_spread_tb.sv -----
// fire_heat_spread_tb: self-checking testbench for the fire heat spread block
// drives init, spread, read and no-op words under random bursts and output stalls,
// predicts every result word from its own copy of the heat grid; depends on fhs_pkg

module fire_heat_spread_tb;

    localparam int IDLE_LIMIT   = 40000;
    localparam int RANDOM_WORDS = 1750;

    // register indexes that decode to nothing
    localparam logic [fhs_pkg::CFG_IW-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [fhs_pkg::CFG_IW-1:0] REG_UNMAPPED_HI = 2'd3;

    // flame colors, coldest first, packed as red green blue
    localparam logic [3*fhs_pkg::RGB_W-1:0] FLAME_RGB [36] = '{
        24'h070707, 24'h1f0707, 24'h2f0f07, 24'h470f07, 24'h571707, 24'h671f07,
        24'h771f07, 24'h8f2707, 24'h9f2f07, 24'haf3f07, 24'hbf4707, 24'hc74707,
        24'hdf4f07, 24'hdf5707, 24'hdf5707, 24'hd75f07, 24'hd7670f, 24'hcf6f0f,
        24'hcf770f, 24'hcf7f0f, 24'hcf8717, 24'hc78717, 24'hc78f17, 24'hc7971f,
        24'hbf9f1f, 24'hbf9f1f, 24'hbfa727, 24'hbfa727, 24'hbfaf2f, 24'hb7af2f,
        24'hb7b72f, 24'hb7b737, 24'hcfcf6f, 24'hdfdf9f, 24'hefefc7, 24'hffffff
    };

    typedef struct packed {
        fhs_pkg::t_req                kind;
        logic [fhs_pkg::PIX_W-1:0]    pix;
        logic [fhs_pkg::DRIFT_W-1:0]  drift;
        logic [fhs_pkg::DECAY_W-1:0]  decay;
    } t_fire_req;

    typedef struct packed {
        logic [fhs_pkg::PIX_W-1:0]  cell_idx;
        logic [fhs_pkg::HEAT_W-1:0] heat;
        logic [fhs_pkg::RGB_W-1:0]  red;
        logic [fhs_pkg::RGB_W-1:0]  green;
        logic [fhs_pkg::RGB_W-1:0]  blue;
        logic                       pass_end;
    } t_heat_word;

    // clock, reset and block ports
    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    t_fire_req                    in_req = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [fhs_pkg::PIX_W-1:0]    o_cell_index;
    logic [fhs_pkg::HEAT_W-1:0]   o_heat;
    logic [fhs_pkg::RGB_W-1:0]    o_red;
    logic [fhs_pkg::RGB_W-1:0]    o_green;
    logic [fhs_pkg::RGB_W-1:0]    o_blue;
    logic                         o_pass_end;
    logic                         cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [fhs_pkg::CFG_IW-1:0]   cfg_index = '0;
    logic [fhs_pkg::CFG_DW-1:0]   cfg_data = '0;

    // predicted grid, geometry and scan position
    logic [fhs_pkg::HEAT_W-1:0]   heat_grid [fhs_pkg::MAX_CELLS];
    logic [fhs_pkg::WIDTH_W-1:0]  grid_cols;
    logic [fhs_pkg::HEIGHT_W-1:0] grid_rows;
    int                           scan_row;
    int                           scan_col;

    // words waiting to be sent and result words due
    t_fire_req                    fire_reqs[$];
    t_heat_word                   heat_words_due[$];

    // sender and receiver pacing
    int                           burst_left = 1;
    int                           gap_left = 0;
    int                           stall_mode = 0;
    int                           stall_left = 0;
    int                           idle_cycles = 0;

    // run statistics
    int                           words_sent = 0;
    int                           spreads_sent = 0;
    int                           reads_sent = 0;
    int                           inits_sent = 0;
    int                           words_checked = 0;
    int                           passes_seen = 0;
    int                           reg_writes = 0;
    int                           random_words = 0;
    int                           mismatches = 0;

    fire_heat_spread i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (in_req.kind),
        .i_pixel_index (in_req.pix),
        .i_drift       (in_req.drift),
        .i_decay       (in_req.decay),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cell_index  (o_cell_index),
        .o_heat        (o_heat),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_pass_end    (o_pass_end),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // 20-unit clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // effective geometry after clamping
    function automatic int cols_in_use();
        if (grid_cols < fhs_pkg::WIDTH_MIN) return int'(fhs_pkg::WIDTH_MIN);
        if (grid_cols > fhs_pkg::WIDTH_MAX) return int'(fhs_pkg::WIDTH_MAX);
        return int'(grid_cols);
    endfunction

    function automatic int rows_in_use();
        if (grid_rows < fhs_pkg::HEIGHT_MIN) return int'(fhs_pkg::HEIGHT_MIN);
        if (grid_rows > fhs_pkg::HEIGHT_MAX) return int'(fhs_pkg::HEIGHT_MAX);
        return int'(grid_rows);
    endfunction

    function automatic int cells_in_use();
        int n;
        n = cols_in_use() * rows_in_use();
        return (n < fhs_pkg::MAX_CELLS) ? n : fhs_pkg::MAX_CELLS;
    endfunction

    function automatic void restart_scan();
        scan_row = rows_in_use() - 1;
        scan_col = 0;
    endfunction

    // clear the grid and light the bottom row
    function automatic void rekindle_grid();
        int base;
        base = (rows_in_use() - 1) * cols_in_use();
        for (int i = 0; i < fhs_pkg::MAX_CELLS; i++) heat_grid[i] = '0;
        for (int j = 0; j < cols_in_use(); j++)
            if (base + j < fhs_pkg::MAX_CELLS) heat_grid[base + j] = fhs_pkg::HEAT_MAX;
        restart_scan();
    endfunction

    // one accepted word: update the grid and return the result word it causes
    function automatic t_heat_word advance_fire(input t_fire_req rq);
        t_heat_word w;
        int cols, src, h, drop, nh, dst;
        w = '0;
        case (rq.kind)
            fhs_pkg::REQ_INIT: begin
                rekindle_grid();
            end
            fhs_pkg::REQ_SPREAD: begin
                cols = cols_in_use();
                src  = scan_row * cols + scan_col;
                h    = (src < fhs_pkg::MAX_CELLS) ? int'(heat_grid[src]) : 0;
                drop = int'(rq.decay) + 2;
                nh   = (h > drop) ? h - drop : 0;
                // one row up, shifted by drift - 1, floored at cell 0
                if (src + int'(rq.drift) < cols + 1) dst = 0;
                else dst = src + int'(rq.drift) - cols - 1;
                if (dst < cells_in_use()) heat_grid[dst] = fhs_pkg::HEAT_W'(nh);
                w.cell_idx = fhs_pkg::PIX_W'(dst);
                w.heat     = fhs_pkg::HEAT_W'(nh);
                scan_col++;
                if (scan_col >= cols) begin
                    scan_col = 0;
                    if (scan_row <= 1) begin
                        restart_scan();
                        w.pass_end = 1'b1;
                    end else begin
                        scan_row--;
                    end
                end
            end
            fhs_pkg::REQ_READ: begin
                w.cell_idx = rq.pix;
                if (int'(rq.pix) < cells_in_use()) begin
                    h = int'(heat_grid[rq.pix]);
                    w.heat = fhs_pkg::HEAT_W'(h);
                    if (h <= int'(fhs_pkg::HEAT_MAX))
                        {w.red, w.green, w.blue} = FLAME_RGB[h];
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic void queue_req(input fhs_pkg::t_req kind, input int pix,
                                      input int drift, input int decay);
        fire_reqs.push_back('{kind, fhs_pkg::PIX_W'(pix), fhs_pkg::DRIFT_W'(drift),
                              fhs_pkg::DECAY_W'(decay)});
    endfunction

    // random word, mostly spreads and in-grid reads, with rare inits
    function automatic t_fire_req random_req();
        t_fire_req rq;
        int sel, cells;
        cells    = cells_in_use();
        rq.pix   = fhs_pkg::PIX_W'($urandom_range(0, 8191));
        rq.drift = fhs_pkg::DRIFT_W'($urandom_range(0, 3));
        rq.decay = fhs_pkg::DECAY_W'($urandom_range(0, 7));
        sel = $urandom_range(0, 199);
        if (sel < 2) rq.kind = fhs_pkg::REQ_INIT;
        else if (sel < 122) rq.kind = fhs_pkg::REQ_SPREAD;
        else if (sel < 194) rq.kind = fhs_pkg::REQ_READ;
        else rq.kind = fhs_pkg::REQ_NOP;
        if (rq.kind == fhs_pkg::REQ_READ) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) rq.pix = fhs_pkg::PIX_W'($urandom_range(0, cells - 1));
            else if (sel == 7) rq.pix = fhs_pkg::PIX_W'(cells - 1 + $urandom_range(0, 1));
        end
        return rq;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // register write over the configuration channel, then mirror it
    task automatic write_reg(input logic [fhs_pkg::CFG_IW-1:0] idx,
                             input logic [fhs_pkg::CFG_DW-1:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            fhs_pkg::REG_GRID_WIDTH: begin
                grid_cols = data;
                restart_scan();
            end
            fhs_pkg::REG_GRID_HEIGHT: begin
                grid_rows = data[fhs_pkg::HEIGHT_W-1:0];
                restart_scan();
            end
            default: ;
        endcase
    endtask

    // all words sent and answered, and no sweep holding the input off
    task automatic wait_idle();
        int quiet;
        do @(negedge i_clk);
        while (fire_reqs.size() != 0 || in_valid || heat_words_due.size() != 0);
        quiet = 0;
        while (quiet < 4) begin
            @(negedge i_clk);
            quiet = o_in_stall ? 0 : quiet + 1;
        end
    endtask

    // one random geometry and a batch of random words
    task automatic run_random_phase();
        int geo, cols, rows, n;
        geo = $urandom_range(0, 9);
        if (geo < 5) begin
            cols = $urandom_range(1, 8);
            rows = $urandom_range(2, 6);
        end else if (geo < 7) begin
            cols = $urandom_range(9, 40);
            rows = $urandom_range(7, 20);
        end else if (geo == 7) begin
            cols = $urandom_range(128, 255);
            rows = $urandom_range(64, 255);
        end else if (geo == 8) begin
            cols = $urandom_range(0, 1);
            rows = $urandom_range(0, 1) + ($urandom_range(0, 1) ? 128 : 0);
        end else begin
            cols = $urandom_range(0, 255);
            rows = $urandom_range(0, 255);
        end
        if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 4) != 0)
                write_reg(fhs_pkg::REG_GRID_WIDTH, fhs_pkg::CFG_DW'(cols));
            write_reg(fhs_pkg::REG_GRID_HEIGHT, fhs_pkg::CFG_DW'(rows));
        end else begin
            if ($urandom_range(0, 4) != 0)
                write_reg(fhs_pkg::REG_GRID_HEIGHT, fhs_pkg::CFG_DW'(rows));
            write_reg(fhs_pkg::REG_GRID_WIDTH, fhs_pkg::CFG_DW'(cols));
        end
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                      fhs_pkg::CFG_DW'($urandom_range(0, 255)));
        n = (geo < 5) ? $urandom_range(60, 160) : $urandom_range(40, 120);
        @(negedge i_clk);
        if ($urandom_range(0, 1)) queue_req(fhs_pkg::REQ_INIT, 0, 0, 0);
        repeat (n) fire_reqs.push_back(random_req());
        random_words += n;
        wait_idle();
    endtask

    // sender: bursts of words with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                heat_words_due.push_back(advance_fire(in_req));
                words_sent++;
                case (in_req.kind)
                    fhs_pkg::REQ_INIT:   inits_sent++;
                    fhs_pkg::REQ_SPREAD: spreads_sent++;
                    fhs_pkg::REQ_READ:   reads_sent++;
                    default: ;
                endcase
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (fire_reqs.size() > 0) begin
                    in_req   <= fire_reqs.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each taken word against the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (heat_words_due.size() == 0) begin
                $display("%0t: result word with nothing due, cell %0d heat %0d",
                         $time, o_cell_index, o_heat);
                mismatches++;
            end else begin
                t_heat_word want;
                want = heat_words_due.pop_front();
                check_field("cell_index", want.cell_idx, o_cell_index);
                check_field("heat", want.heat, o_heat);
                check_field("red", want.red, o_red);
                check_field("green", want.green, o_green);
                check_field("blue", want.blue, o_blue);
                check_field("pass_end", want.pass_end, o_pass_end);
                words_checked++;
                if (want.pass_end) passes_seen++;
            end
        end
        // stall pattern: open, coin flip, periodic or heavy, switched now and then
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 120);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= 1'($urandom_range(0, 1));
            2:       i_out_stall <= ((stall_left % 4) == 0);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        grid_cols = fhs_pkg::RST_WIDTH;
        grid_rows = fhs_pkg::RST_HEIGHT;
        rekindle_grid();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default geometry: grid edges, palette ends, drift and decay extremes, init
        @(negedge i_clk);
        queue_req(fhs_pkg::REQ_READ, 0, 3, 7);
        queue_req(fhs_pkg::REQ_READ, 1919, 0, 0);
        queue_req(fhs_pkg::REQ_READ, 1920, 0, 0);
        queue_req(fhs_pkg::REQ_READ, 8191, 0, 0);
        queue_req(fhs_pkg::REQ_NOP, 8191, 3, 7);
        queue_req(fhs_pkg::REQ_SPREAD, 0, 0, 0);
        queue_req(fhs_pkg::REQ_SPREAD, 0, 3, 7);
        queue_req(fhs_pkg::REQ_SPREAD, 0, 1, 6);
        queue_req(fhs_pkg::REQ_SPREAD, 0, 2, 5);
        queue_req(fhs_pkg::REQ_READ, 1759, 0, 0);
        queue_req(fhs_pkg::REQ_READ, 1763, 0, 0);
        queue_req(fhs_pkg::REQ_INIT, 8191, 3, 7);
        queue_req(fhs_pkg::REQ_READ, 1759, 0, 0);
        queue_req(fhs_pkg::REQ_READ, 1840, 0, 0);
        queue_req(fhs_pkg::REQ_SPREAD, 0, 2, 0);
        wait_idle();

        // 2x2 grid: destination below cell 0, then a pass end
        write_reg(fhs_pkg::REG_GRID_WIDTH, 8'd2);
        write_reg(fhs_pkg::REG_GRID_HEIGHT, 8'd2);
        @(negedge i_clk);
        queue_req(fhs_pkg::REQ_SPREAD, 0, 0, 1);
        queue_req(fhs_pkg::REQ_SPREAD, 0, 3, 0);
        queue_req(fhs_pkg::REQ_READ, 0, 0, 0);
        queue_req(fhs_pkg::REQ_READ, 3, 0, 0);
        queue_req(fhs_pkg::REQ_READ, 4, 0, 0);
        wait_idle();

        // clamped 1x2 grid: destination past the grid, unmapped register
        write_reg(fhs_pkg::REG_GRID_WIDTH, 8'd0);
        write_reg(fhs_pkg::REG_GRID_HEIGHT, 8'd1);
        write_reg(REG_UNMAPPED_LO, 8'd5);
        @(negedge i_clk);
        queue_req(fhs_pkg::REQ_SPREAD, 0, 3, 0);
        queue_req(fhs_pkg::REQ_SPREAD, 0, 0, 7);
        queue_req(fhs_pkg::REQ_READ, 1, 0, 0);
        queue_req(fhs_pkg::REQ_READ, 2, 0, 0);
        wait_idle();

        while (random_words < RANDOM_WORDS) run_random_phase();
        wait_idle();
        repeat (4) @(posedge i_clk);

        $display("tb: sent %0d words (%0d spread, %0d read, %0d init) over %0d register writes",
                 words_sent, spreads_sent, reads_sent, inits_sent, reg_writes);
        $display("tb: checked %0d result words, %0d full passes, %0d mismatches",
                 words_checked, passes_seen, mismatches);
        if (mismatches == 0 && heat_words_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/fhs_pkg.sv
rtl/fhs_cfg.sv
rtl/fhs_scan.sv
rtl/fhs_grid.sv
rtl/fire_heat_spread.sv
verif/fire_heat_spread_tb.sv
